>>> rtl/core/idel_pkg.sv
package idel_pkg;

    localparam int IDX_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [2:0] MODE_ADD_FRONT = 3'd0;
    localparam logic [2:0] MODE_ADD_BACK  = 3'd1;
    localparam logic [2:0] MODE_REM_FRONT = 3'd2;
    localparam logic [2:0] MODE_REM_BACK  = 3'd3;
    localparam logic [2:0] MODE_CLEAR     = 3'd4;
    localparam logic [2:0] MODE_INSERT    = 3'd5;
    localparam logic [2:0] MODE_REM_AT    = 3'd6;
    localparam logic [2:0] MODE_DUMP      = 3'd7;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_REM  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  pos;
        logic [IDX_W-1:0]  last;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

>>> rtl/core/indexed_double_ended_list.sv
// ordered list of signed 32-bit words held in a row of cells, front at cell 0
// slave channel: tuser = mode, tdata = position and value; one transfer per operation
// master channel: tuser = status, tdata = element, tlast = final result of the operation
// every operation but dump gives one status result, registered after its transfer
// add, insert and remove at the front or at a position shift the cells at and above it at once
// a dump first sets the dump state, then gives one result per stored element, each
// taken from cell 0 through the result register; the row rotates one place per
// result, cell 0 feeds the output, and after count results the list is back in order
// a dump of an empty list gives one status result instead
// a result register plus one pending register part the two sides: one more
// operation is taken while a result waits; then the slave side holds off
// during a dump the slave side is held off until its final result is in the
// result register; a stalled receiver simply pauses the rotation
// reset clears the element count and all handshake state; cell contents are
// not cleared and are never read beyond the count
module indexed_double_ended_list #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // position[6:0], value[38:7], zero pad
    input  logic [2:0]  i_s_tuser,   // mode[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // element[31:0]
    output logic [1:0]  o_m_tuser,   // status[1:0]
    output logic        o_m_tlast
);
    import idel_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic [CW-1:0]     r_left;
    logic              r_dump;
    logic              r_ovld;
    logic              r_pend_vld;
    logic [1:0]        r_ost;
    logic [DATA_W-1:0] r_oel;
    logic              r_olast;
    logic [1:0]        r_pst;

    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic [2:0]        mode;
    logic [IDX_W-1:0]  cnt_x;
    logic              full;
    logic              empty;
    logic              acc;
    logic              slot_free;
    logic              emit_dump;
    logic              start_dump;
    logic              result_now;
    logic [1:0]        st;
    logic [1:0]        req_op;
    logic [IDX_W-1:0]  req_pos;
    t_cell_cmd         cell_cmd;

    logic [DATA_W-1:0] cell_data [CAPACITY];

    assign pos   = i_s_tdata[6:0];
    assign value = i_s_tdata[38:7];
    assign mode  = i_s_tuser;
    assign cnt_x = IDX_W'(r_cnt);
    assign full  = (r_cnt == CW'(CAPACITY));
    assign empty = (r_cnt == '0);

    assign slot_free  = !r_ovld || i_m_tready;
    assign o_s_tready = !r_dump && !r_pend_vld;
    assign acc        = i_s_tvalid && o_s_tready;
    assign emit_dump  = r_dump && slot_free;
    assign result_now = acc && !start_dump;

    always_comb begin
        st         = ST_OK;
        req_op     = CELL_HOLD;
        req_pos    = pos;
        n_cnt      = r_cnt;
        start_dump = 1'b0;
        case (mode)
            MODE_ADD_FRONT, MODE_ADD_BACK: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    req_op  = CELL_INS;
                    req_pos = (mode == MODE_ADD_FRONT) ? '0 : cnt_x;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            MODE_REM_FRONT: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    req_op  = CELL_REM;
                    req_pos = '0;
                    n_cnt   = r_cnt - 1'b1;
                end
            end
            MODE_REM_BACK: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            MODE_CLEAR: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    n_cnt = '0;
                end
            end
            MODE_INSERT: begin
                if (pos >= cnt_x) begin
                    st = ST_BADPOS;
                end else if (full) begin
                    st = ST_FULL;
                end else begin
                    req_op = CELL_INS;
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            MODE_REM_AT: begin
                if (pos == '0 || pos > cnt_x) begin
                    st = ST_BADPOS;
                end else begin
                    req_op  = CELL_REM;
                    req_pos = pos - 1'b1;
                    n_cnt   = r_cnt - 1'b1;
                end
            end
            default: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    start_dump = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        cell_cmd.pos   = req_pos;
        cell_cmd.last  = cnt_x - 1'b1;
        cell_cmd.value = value;
        if (acc) begin
            cell_cmd.op = req_op;
        end else if (emit_dump) begin
            cell_cmd.op = CELL_ROT;
        end else begin
            cell_cmd.op = CELL_HOLD;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        idel_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (cell_cmd),
            .i_left ((g == 0) ? value : cell_data[(g == 0) ? 0 : g - 1]),
            .i_right((g == CAPACITY - 1) ? cell_data[0]
                                         : cell_data[(g == CAPACITY - 1) ? 0 : g + 1]),
            .i_wrap (cell_data[0]),
            .o_data (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_left     <= '0;
            r_dump     <= 1'b0;
            r_ovld     <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_cnt <= n_cnt;
            end
            if (acc && start_dump) begin
                r_dump <= 1'b1;
                r_left <= r_cnt;
            end else if (emit_dump) begin
                r_left <= r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    r_dump <= 1'b0;
                end
            end
            if (slot_free) begin
                r_ovld <= r_pend_vld || emit_dump || result_now;
                if (r_pend_vld) begin
                    r_pend_vld <= 1'b0;
                end
            end else if (result_now) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_pend_vld) begin
                r_ost   <= r_pst;
                r_oel   <= '0;
                r_olast <= 1'b1;
            end else if (emit_dump) begin
                r_ost   <= ST_OK;
                r_oel   <= cell_data[0];
                r_olast <= (r_left == CW'(1));
            end else begin
                r_ost   <= st;
                r_oel   <= '0;
                r_olast <= 1'b1;
            end
        end else if (result_now) begin
            r_pst <= st;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_oel;
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_olast;

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> r_ovld)
        else $error("pending result without result in output register");

    a_dump_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dump |-> !r_pend_vld)
        else $error("pending status during dump");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dump |-> (r_left != '0 && r_left <= r_cnt))
        else $error("dump counter out of range");

endmodule

>>> rtl/core/idel_cell.sv
module idel_cell #(
    parameter int INDEX = 0
) (
    input  logic                      i_clk,
    input  idel_pkg::t_cell_cmd       i_cmd,
    input  logic [idel_pkg::DATA_W-1:0] i_left,
    input  logic [idel_pkg::DATA_W-1:0] i_right,
    input  logic [idel_pkg::DATA_W-1:0] i_wrap,
    output logic [idel_pkg::DATA_W-1:0] o_data
);
    import idel_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_INS: begin
                if (MY_IDX == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end else if (MY_IDX > i_cmd.pos) begin
                    n_data = i_left;
                end
            end
            CELL_REM: begin
                if (MY_IDX >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            CELL_ROT: begin
                if (MY_IDX == i_cmd.last) begin
                    n_data = i_wrap;
                end else begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
